@@ rtl/core/mev_pkg.sv @@
// Memo envelope validator package: memo geometry, field kind codes,
// configuration register indexes and the fixed header layout.
// No dependencies.
`timescale 1ns / 1ps

package mev_pkg;

    // Memo geometry
    localparam int MEMO_BYTES         = 512;
    localparam int IDENTITY_DOC_BYTES = 151;
    localparam int POS_W              = $clog2(MEMO_BYTES);
    // Wide enough for any field boundary, up to 91 + 255 + 64 + 151
    localparam int BND_W              = 11;

    localparam int FIXED_HEAD   = 91;
    localparam int TRAILER_LEN  = 64;
    localparam int COMMIT_BYTES = 32;
    localparam int REPLY_BYTES  = 32;

    // Flag bits
    localparam logic [7:0] FLAG_IDENT = 8'h01;
    localparam logic [7:0] FLAG_REPLY = 8'h02;

    // Field kind codes
    typedef logic [4:0] kind_t;
    localparam kind_t KIND_MAGIC     = 5'd0;
    localparam kind_t KIND_VERSION   = 5'd1;
    localparam kind_t KIND_NETWORK   = 5'd2;
    localparam kind_t KIND_TYPE      = 5'd3;
    localparam kind_t KIND_FLAGS     = 5'd4;
    localparam kind_t KIND_LENGTH    = 5'd5;
    localparam kind_t KIND_CREATED   = 5'd6;
    localparam kind_t KIND_EXPIRES   = 5'd7;
    localparam kind_t KIND_NONCE     = 5'd8;
    localparam kind_t KIND_REQUEST   = 5'd9;
    localparam kind_t KIND_INVOICE   = 5'd10;
    localparam kind_t KIND_ASSET_LEN = 5'd11;
    localparam kind_t KIND_ASSET     = 5'd12;
    localparam kind_t KIND_COMMIT    = 5'd13;
    localparam kind_t KIND_REPLY     = 5'd14;
    localparam kind_t KIND_IDENTITY  = 5'd15;
    localparam kind_t KIND_PAD       = 5'd16;

    // Configuration register indexes
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_FORMAT_VERSION  = 3'd0;
    localparam cfg_idx_t CFG_HIGHEST_NETWORK = 3'd1;
    localparam cfg_idx_t CFG_LOWEST_TYPE     = 3'd2;
    localparam cfg_idx_t CFG_HIGHEST_TYPE    = 3'd3;
    localparam cfg_idx_t CFG_ASSET_LIMIT     = 3'd4;
    localparam cfg_idx_t CFG_PAD_VALUE       = 3'd5;

    // Start offsets of the fixed header fields, indexed by kind code
    localparam logic [6:0] HEAD_START [12] = '{
        7'd0, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd10, 7'd18, 7'd26, 7'd42, 7'd58, 7'd90
    };

    // Expected magic bytes
    localparam logic [7:0] MAGIC [4] = '{8'h5A, 8'h50, 8'h41, 8'h59};

endpackage

@@ rtl/core/memo_envelope_validator_unit.sv @@
// Memo envelope validator top level: byte tagging, envelope checks and
// the result register. Depends on mev_pkg.
`timescale 1ns / 1ps

// Takes one memo byte per cycle on memo_valid/memo_ready and returns one
// tagged result per byte on result_valid/result_ready. Each byte is decoded
// against a position counter and a few stored header fields in a single
// combinational pass, and the result lands in one output register, so the
// block sustains one byte per cycle while result_ready is high. memo_ready
// is high whenever the output register is empty or is being drained in the
// same cycle. The memo is mev_pkg::MEMO_BYTES bytes long; on its last byte
// end_of_memo is 1 and memo_ok carries the verdict, and the header state
// clears for the next memo. Configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at once and should be made only while idle.
module memo_envelope_validator_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    input  logic        memo_valid,
    output logic        memo_ready,
    input  logic [7:0]  memo_byte,

    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  data_byte,
    output logic [4:0]  field_kind,
    output logic [7:0]  byte_in_field,
    output logic        end_of_memo,
    output logic        memo_ok,
    output logic [7:0]  network_code,
    output logic [7:0]  msg_type,
    output logic        reply_flag,
    output logic        identity_flag,
    output logic [63:0] created_time,
    output logic [63:0] expiry_time,
    output logic [7:0]  asset_length
);

    localparam int BW = mev_pkg::BND_W;

    // Configuration registers
    logic [7:0] format_version_reg;
    logic [7:0] highest_network_reg;
    logic [7:0] lowest_type_reg;
    logic [7:0] highest_type_reg;
    logic [7:0] asset_limit_reg;
    logic [7:0] pad_value_reg;

    // Memo state
    logic [mev_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      all_ok_reg, all_ok_next;
    logic [7:0]                flag_bits_reg, flag_bits_next;
    logic [15:0]               declared_reg, declared_next;
    logic [7:0]                asset_count_reg, asset_count_next;
    logic [7:0]                net_reg, net_next;
    logic [7:0]                type_reg, type_next;
    logic [63:0]               created_reg, created_next;
    logic [63:0]               expiry_reg, expiry_next;

    // Output register
    logic                  out_valid_reg;
    logic [7:0]            data_reg;
    mev_pkg::kind_t        kind_reg;
    logic [7:0]            off_reg;
    logic                  last_reg;
    logic                  ok_reg;

    // Decode signals
    logic                  accept;
    logic                  last;
    logic [BW-1:0]         pos_ext;
    logic [BW-1:0]         a_end, c_end, r_end, i_end, expected;
    logic [BW-1:0]         ident_len;
    mev_pkg::kind_t        kind;
    logic [7:0]            off;
    logic                  byte_ok;
    logic                  char_ok;
    logic                  final_ok;
    logic                  verdict;

    assign memo_ready = !out_valid_reg || result_ready;
    assign accept     = memo_valid && memo_ready;

    assign pos_ext   = BW'(pos_reg);
    assign last      = (pos_reg == mev_pkg::POS_W'(mev_pkg::MEMO_BYTES - 1));
    assign ident_len = ((flag_bits_reg & mev_pkg::FLAG_IDENT) != 8'd0)
                     ? BW'(mev_pkg::IDENTITY_DOC_BYTES) : '0;

    // Variable-field boundaries past the fixed header
    assign a_end = BW'(mev_pkg::FIXED_HEAD) + BW'(asset_count_reg);
    assign c_end = a_end + BW'(mev_pkg::COMMIT_BYTES);
    assign r_end = c_end + BW'(mev_pkg::REPLY_BYTES);
    assign i_end = r_end + ident_len;

    // Asset characters: A-Z, 0-9, colon, dash, underscore
    assign char_ok = (memo_byte >= 8'h41 && memo_byte <= 8'h5A)
                  || (memo_byte >= 8'h30 && memo_byte <= 8'h39)
                  || (memo_byte == 8'h3A) || (memo_byte == 8'h2D)
                  || (memo_byte == 8'h5F);

    // Tag the byte and update the header state
    always_comb
    begin
        kind             = mev_pkg::KIND_MAGIC;
        off              = 8'(pos_reg);
        byte_ok          = 1'b1;
        flag_bits_next   = flag_bits_reg;
        declared_next    = declared_reg;
        asset_count_next = asset_count_reg;
        net_next         = net_reg;
        type_next        = type_reg;
        created_next     = created_reg;
        expiry_next      = expiry_reg;

        if (pos_ext < BW'(mev_pkg::FIXED_HEAD))
        begin
            for (int k = 1; k < 12; k++)
            begin
                if (pos_ext >= BW'(mev_pkg::HEAD_START[k]))
                begin
                    kind = 5'(k);
                    off  = 8'(pos_ext - BW'(mev_pkg::HEAD_START[k]));
                end
            end

            case (kind)
                mev_pkg::KIND_MAGIC:
                begin
                    byte_ok = (memo_byte == mev_pkg::MAGIC[off[1:0]]);
                end
                mev_pkg::KIND_VERSION:
                begin
                    byte_ok = (memo_byte == format_version_reg);
                end
                mev_pkg::KIND_NETWORK:
                begin
                    net_next = memo_byte;
                    byte_ok  = (memo_byte <= highest_network_reg);
                end
                mev_pkg::KIND_TYPE:
                begin
                    type_next = memo_byte;
                    byte_ok   = (memo_byte >= lowest_type_reg)
                             && (memo_byte <= highest_type_reg);
                end
                mev_pkg::KIND_FLAGS:
                begin
                    flag_bits_next = memo_byte;
                    byte_ok = ((memo_byte & ~(mev_pkg::FLAG_IDENT | mev_pkg::FLAG_REPLY))
                               == 8'd0);
                end
                mev_pkg::KIND_LENGTH:
                begin
                    declared_next = declared_reg | (16'(memo_byte) << {off[0], 3'b000});
                end
                mev_pkg::KIND_CREATED:
                begin
                    created_next = created_reg | (64'(memo_byte) << {off[2:0], 3'b000});
                end
                mev_pkg::KIND_EXPIRES:
                begin
                    expiry_next = expiry_reg | (64'(memo_byte) << {off[2:0], 3'b000});
                end
                mev_pkg::KIND_ASSET_LEN:
                begin
                    asset_count_next = memo_byte;
                    byte_ok = (memo_byte != 8'd0) && (memo_byte <= asset_limit_reg);
                end
                default:
                begin
                    byte_ok = 1'b1;
                end
            endcase
        end
        else if (pos_ext < a_end)
        begin
            kind    = mev_pkg::KIND_ASSET;
            off     = 8'(pos_ext - BW'(mev_pkg::FIXED_HEAD));
            byte_ok = char_ok;
        end
        else if (pos_ext < c_end)
        begin
            kind = mev_pkg::KIND_COMMIT;
            off  = 8'(pos_ext - a_end);
        end
        else if (pos_ext < r_end)
        begin
            kind    = mev_pkg::KIND_REPLY;
            off     = 8'(pos_ext - c_end);
            byte_ok = ((flag_bits_reg & mev_pkg::FLAG_REPLY) != 8'd0)
                   || (memo_byte == 8'd0);
        end
        else if (pos_ext < i_end)
        begin
            kind = mev_pkg::KIND_IDENTITY;
            off  = 8'(pos_ext - r_end);
        end
        else
        begin
            kind    = mev_pkg::KIND_PAD;
            off     = 8'(pos_ext - i_end);
            byte_ok = (memo_byte == pad_value_reg);
        end
    end

    // End-of-memo checks: declared length, fit within the memo and time order
    assign expected = BW'(mev_pkg::FIXED_HEAD) + BW'(asset_count_next)
                    + BW'(mev_pkg::TRAILER_LEN)
                    + (((flag_bits_next & mev_pkg::FLAG_IDENT) != 8'd0)
                       ? BW'(mev_pkg::IDENTITY_DOC_BYTES) : BW'(0));
    assign final_ok = (expected <= BW'(mev_pkg::MEMO_BYTES))
                   && (declared_next == 16'(expected))
                   && (expiry_next > created_next);

    assign all_ok_next = all_ok_reg && byte_ok;
    assign verdict     = last && all_ok_next && final_ok;
    assign pos_next    = pos_reg + mev_pkg::POS_W'(1);

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_version_reg  <= 8'd1;
            highest_network_reg <= 8'd2;
            lowest_type_reg     <= 8'd1;
            highest_type_reg    <= 8'd3;
            asset_limit_reg     <= 8'd16;
            pad_value_reg       <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mev_pkg::CFG_FORMAT_VERSION:  format_version_reg  <= cfg_data;
                mev_pkg::CFG_HIGHEST_NETWORK: highest_network_reg <= cfg_data;
                mev_pkg::CFG_LOWEST_TYPE:     lowest_type_reg     <= cfg_data;
                mev_pkg::CFG_HIGHEST_TYPE:    highest_type_reg    <= cfg_data;
                mev_pkg::CFG_ASSET_LIMIT:     asset_limit_reg     <= cfg_data;
                mev_pkg::CFG_PAD_VALUE:       pad_value_reg       <= cfg_data;
                default:                      pad_value_reg       <= pad_value_reg;
            endcase
        end
    end

    // Advance the memo state on each accepted item, clear it after the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            all_ok_reg      <= 1'b1;
            flag_bits_reg   <= '0;
            declared_reg    <= '0;
            asset_count_reg <= '0;
            net_reg         <= '0;
            type_reg        <= '0;
            created_reg     <= '0;
            expiry_reg      <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                pos_reg         <= '0;
                all_ok_reg      <= 1'b1;
                flag_bits_reg   <= '0;
                declared_reg    <= '0;
                asset_count_reg <= '0;
                net_reg         <= '0;
                type_reg        <= '0;
                created_reg     <= '0;
                expiry_reg      <= '0;
            end
            else
            begin
                pos_reg         <= pos_next;
                all_ok_reg      <= all_ok_next;
                flag_bits_reg   <= flag_bits_next;
                declared_reg    <= declared_next;
                asset_count_reg <= asset_count_next;
                net_reg         <= net_next;
                type_reg        <= type_next;
                created_reg     <= created_next;
                expiry_reg      <= expiry_next;
            end
        end
    end

    // Result valid: set on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: load on accept, hold otherwise
    logic [7:0]  rnet_reg, rtype_reg, rasset_reg;
    logic        rreply_reg, rident_reg;
    logic [63:0] rcreated_reg, rexpiry_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg     <= memo_byte;
            kind_reg     <= kind;
            off_reg      <= off;
            last_reg     <= last;
            ok_reg       <= verdict;
            rnet_reg     <= net_next;
            rtype_reg    <= type_next;
            rreply_reg   <= ((flag_bits_next & mev_pkg::FLAG_REPLY) != 8'd0);
            rident_reg   <= ((flag_bits_next & mev_pkg::FLAG_IDENT) != 8'd0);
            rcreated_reg <= created_next;
            rexpiry_reg  <= expiry_next;
            rasset_reg   <= asset_count_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign data_byte     = data_reg;
    assign field_kind    = kind_reg;
    assign byte_in_field = off_reg;
    assign end_of_memo   = last_reg;
    assign memo_ok       = ok_reg;
    assign network_code  = rnet_reg;
    assign msg_type      = rtype_reg;
    assign reply_flag    = rreply_reg;
    assign identity_flag = rident_reg;
    assign created_time  = rcreated_reg;
    assign expiry_time   = rexpiry_reg;
    assign asset_length  = rasset_reg;

`ifndef SYNTHESIS
    // A pass verdict only appears on the final byte
    a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ok_reg) |-> last_reg)
        else $error("memo_ok set away from end of memo");

    // The position counter restarts after the final byte
    a_pos_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (pos_reg == '0) && all_ok_reg)
        else $error("memo state not cleared after final byte");

    // Every accepted item shows up in the result register
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item missing from result register");

    // Field kinds never exceed the pad code
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kind_reg <= mev_pkg::KIND_PAD))
        else $error("field kind out of range");
`endif

endmodule
